FILE: rtl/core/ssrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssrp_pkg
// Shared types and codes for the shortest seek request picker: operation and
// status codes, the transfer payloads, the table entry and sequencer state.
// ----------------------------------------------------------------------------
package ssrp_pkg;

  localparam int POS_W     = 48;
  localparam int TAG_W     = 8;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int PENDING_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_IGNORE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_DISPATCHED = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FULL       = 3'd3,
    ST_REMOVED    = 3'd4,
    ST_NOT_FOUND  = 3'd5
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] request_position;
    logic [TAG_W-1:0] request_tag;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     chosen_position;
    logic [TAG_W-1:0]     chosen_tag;
    logic [PENDING_W-1:0] pending_count;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Control from the sequencer to the seek distance unit.
  typedef struct packed {
    logic clear;  // forget the current best candidate
    logic feed;   // a table entry is presented this cycle
  } seek_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_DSP_SCAN,
    S_RMV_SCAN,
    S_SHIFT,
    S_DONE
  } seq_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/ssrp_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssrp_table
// Request table storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module ssrp_table
  import ssrp_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire entry_t           wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output entry_t                rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/ssrp_seek_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssrp_seek_unit
// Shared distance and compare pipeline. Each presented entry passes a
// subtract stage, an absolute value stage and a compare stage that keeps the
// nearest entry seen since the last clear; ties go to the later entry.
// ----------------------------------------------------------------------------
module ssrp_seek_unit
  import ssrp_pkg::*;
#(
  parameter int IDX_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire seek_ctl_t        ctl,
  input  wire entry_t           cand,
  input  wire logic [IDX_W-1:0] cand_idx,
  input  wire logic [POS_W-1:0] last_pos,
  output logic                  busy,
  output entry_t                best,
  output logic [IDX_W-1:0]      best_idx
);

  logic             v1_r;
  logic [POS_W:0]   diff1_r;
  entry_t           e1_r;
  logic [IDX_W-1:0] i1_r;

  logic             v2_r;
  logic [POS_W-1:0] dist2_r;
  entry_t           e2_r;
  logic [IDX_W-1:0] i2_r;

  logic             have_r;
  logic [POS_W-1:0] best_dist_r;
  entry_t           best_r;
  logic [IDX_W-1:0] best_idx_r;

  logic             take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.feed;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.feed) begin
      diff1_r <= {1'b0, cand.pos} - {1'b0, last_pos};
      e1_r    <= cand;
      i1_r    <= cand_idx;
    end
    if (v1_r) begin
      // A negative difference is never larger in magnitude than the position
      // range, so negating the low bits gives the distance.
      dist2_r <= diff1_r[POS_W] ? (~diff1_r[POS_W-1:0]) + POS_W'(1)
                                : diff1_r[POS_W-1:0];
      e2_r    <= e1_r;
      i2_r    <= i1_r;
    end
  end

  assign take = v2_r && (!have_r || (dist2_r <= best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl.clear) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_dist_r <= dist2_r;
      best_r      <= e2_r;
      best_idx_r  <= i2_r;
    end
  end

  assign busy     = v1_r || v2_r;
  assign best     = best_r;
  assign best_idx = best_idx_r;

endmodule
`default_nettype wire

FILE: rtl/core/ssrp_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssrp_seq
// Sequencer: accepts one operation, walks the table through its read port,
// drives the seek unit for a dispatch, matches tags for a remove, closes the
// gap left by a deleted entry and presents one result.
// ----------------------------------------------------------------------------
module ssrp_seq
  import ssrp_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5,
  parameter int CNT_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire in_item_t         in_data,
  output logic                  in_stall,
  output logic                  res_valid,
  input  wire logic             res_take,
  output out_item_t             res_data,
  output logic                  mem_we,
  output logic [IDX_W-1:0]      mem_waddr,
  output entry_t                mem_wdata,
  output logic [IDX_W-1:0]      mem_raddr,
  input  wire entry_t           mem_rdata,
  output seek_ctl_t             seek_ctl,
  output logic [POS_W-1:0]      last_pos,
  input  wire logic             seek_busy,
  input  wire entry_t           seek_best,
  input  wire logic [IDX_W-1:0] seek_best_idx
);

  seq_state_t       state_r, state_nxt;
  op_t              op_in;
  logic [POS_W-1:0] pos_r;
  logic [TAG_W-1:0] tag_r;
  logic [CNT_W-1:0] count_r;
  logic [POS_W-1:0] last_r;
  logic [CNT_W-1:0] rd_ptr_r;
  logic             rdv_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             found_r;
  logic [IDX_W-1:0] slot_r;
  status_t          status_r;
  logic [POS_W-1:0] chosen_pos_r;
  logic [TAG_W-1:0] chosen_tag_r;

  logic accept;
  logic issue;
  logic drained;
  logic full;
  logic tag_hit;

  assign op_in   = op_t'(in_data.operation);
  assign accept  = in_valid && (state_r == S_IDLE);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign tag_hit = rdv_r && !found_r && (mem_rdata.tag == tag_r);
  assign drained = !issue && !rdv_r && !seek_busy;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_ADD:      state_nxt = full ? S_DONE : S_ADD;
            OP_DISPATCH: state_nxt = (count_r == '0) ? S_DONE : S_DSP_SCAN;
            OP_REMOVE:   state_nxt = (count_r == '0) ? S_DONE : S_RMV_SCAN;
            OP_IGNORE:   state_nxt = S_DONE;
          endcase
        end
      end
      S_ADD:      state_nxt = S_DONE;
      S_DSP_SCAN: state_nxt = drained ? S_SHIFT : S_DSP_SCAN;
      S_RMV_SCAN: begin
        if (drained) begin
          state_nxt = found_r ? S_SHIFT : S_DONE;
        end
      end
      S_SHIFT:    state_nxt = drained ? S_DONE : S_SHIFT;
      S_DONE:     state_nxt = res_take ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs and memory control.
  always_comb begin
    in_stall       = (state_r != S_IDLE);
    res_valid      = (state_r == S_DONE);
    issue          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = rd_idx_r - IDX_W'(1);
    mem_wdata      = mem_rdata;
    mem_raddr      = rd_ptr_r[IDX_W-1:0];
    seek_ctl.clear = accept;
    seek_ctl.feed  = 1'b0;
    unique case (state_r)
      S_ADD: begin
        mem_we    = 1'b1;
        mem_waddr = count_r[IDX_W-1:0];
        mem_wdata = '{pos: pos_r, tag: tag_r};
      end
      S_DSP_SCAN: begin
        issue         = (rd_ptr_r < count_r);
        seek_ctl.feed = rdv_r;
      end
      S_RMV_SCAN: begin
        issue = (rd_ptr_r < count_r) && !found_r && !tag_hit;
      end
      S_SHIFT: begin
        // Entry at the read index moves down one slot.
        issue  = (rd_ptr_r < count_r);
        mem_we = rdv_r;
      end
      S_IDLE, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      last_r  <= '0;
      rdv_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= issue;
      if (accept) begin
        found_r <= 1'b0;
      end else if (tag_hit && (state_r == S_RMV_SCAN)) begin
        found_r <= 1'b1;
      end
      if ((state_r == S_ADD)) begin
        count_r <= count_r + CNT_W'(1);
      end else if ((state_r == S_SHIFT) && drained) begin
        count_r <= count_r - CNT_W'(1);
      end
      if ((state_r == S_DSP_SCAN) && drained) begin
        last_r <= seek_best.pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_ptr_r[IDX_W-1:0];
    if (issue) begin
      rd_ptr_r <= rd_ptr_r + CNT_W'(1);
    end
    if (accept) begin
      pos_r        <= in_data.request_position;
      tag_r        <= in_data.request_tag;
      rd_ptr_r     <= '0;
      chosen_pos_r <= '0;
      chosen_tag_r <= '0;
      unique case (op_in)
        OP_ADD:      status_r <= full ? ST_FULL : ST_ADDED;
        OP_DISPATCH: status_r <= ST_EMPTY;
        OP_REMOVE:   status_r <= ST_NOT_FOUND;
        OP_IGNORE:   status_r <= ST_NOT_FOUND;
      endcase
    end
    if (tag_hit && (state_r == S_RMV_SCAN)) begin
      slot_r <= rd_idx_r;
    end
    if ((state_r == S_DSP_SCAN) && drained) begin
      chosen_pos_r <= seek_best.pos;
      chosen_tag_r <= seek_best.tag;
      slot_r       <= seek_best_idx;
      rd_ptr_r     <= CNT_W'(seek_best_idx) + CNT_W'(1);
      status_r     <= ST_DISPATCHED;
    end
    if ((state_r == S_RMV_SCAN) && drained && found_r) begin
      rd_ptr_r <= CNT_W'(slot_r) + CNT_W'(1);
      status_r <= ST_REMOVED;
    end
  end

  assign last_pos                 = last_r;
  assign res_data.status          = status_r;
  assign res_data.chosen_position = chosen_pos_r;
  assign res_data.chosen_tag      = chosen_tag_r;
  assign res_data.pending_count   = PENDING_W'(count_r);

endmodule
`default_nettype wire

FILE: rtl/core/shortest_seek_request_picker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_seek_request_picker
// Pending disk request table with nearest-position dispatch.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH requests in arrival order and handles one
// operation at a time; in_stall stays high until the result has been placed
// in the output register, which may still hold an earlier result waiting for
// transfer. A dispatch walks every pending entry through the single table
// read port and a three-stage distance and compare unit, then closes the gap
// behind the chosen entry, one entry per cycle. A remove walks entries until
// the first tag match and then closes the gap in the same way. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module shortest_seek_request_picker
  import ssrp_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             res_valid;
  logic             res_take;
  out_item_t        res_data;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;
  logic [IDX_W-1:0] cand_idx_r;

  seek_ctl_t        seek_ctl;
  logic [POS_W-1:0] last_pos;
  logic             seek_busy;
  entry_t           seek_best;
  logic [IDX_W-1:0] seek_best_idx;

  ssrp_seq #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .in_stall      (in_stall),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res_data      (res_data),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .seek_ctl      (seek_ctl),
    .last_pos      (last_pos),
    .seek_busy     (seek_busy),
    .seek_best     (seek_best),
    .seek_best_idx (seek_best_idx)
  );

  ssrp_table #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The table read data belongs to the address presented in the cycle before.
  always_ff @(posedge clk) begin
    cand_idx_r <= mem_raddr;
  end

  ssrp_seek_unit #(
    .IDX_W (IDX_W)
  ) u_seek (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (seek_ctl),
    .cand     (mem_rdata),
    .cand_idx (cand_idx_r),
    .last_pos (last_pos),
    .busy     (seek_busy),
    .best     (seek_best),
    .best_idx (seek_best_idx)
  );

  // The sequencer hands over a result once the output register is free.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: sim/ssrp_checker.sv
// ----------------------------------------------------------------------------
// ssrp_checker
// Watches both channels of the shortest seek request picker, keeps its own
// copy of the request table and the head position, predicts the result of
// every accepted request and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module ssrp_checker
  import ssrp_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_data,
  output int             error_count,
  output int             results_owed
);

  entry_t           request_table[$];
  logic [POS_W-1:0] head_pos;
  out_item_t        owed_results[$];

  // Applies one request to the table copy and returns the result it earns.
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t        res;
    int               pick;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] best_span;
    res = '0;
    res.status = ST_NOT_FOUND;
    case (op_t'(req.operation))
      OP_ADD: begin
        if (request_table.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          request_table.push_back('{pos: req.request_position, tag: req.request_tag});
          res.status = ST_ADDED;
        end
      end
      OP_DISPATCH: begin
        if (request_table.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pick = 0;
          best_span = '0;
          // The later entry wins a tie, hence the less-or-equal test.
          foreach (request_table[i]) begin
            span = (request_table[i].pos >= head_pos) ? request_table[i].pos - head_pos
                                                      : head_pos - request_table[i].pos;
            if (i == 0 || span <= best_span) begin
              best_span = span;
              pick = i;
            end
          end
          res.status = ST_DISPATCHED;
          res.chosen_position = request_table[pick].pos;
          res.chosen_tag = request_table[pick].tag;
          head_pos = request_table[pick].pos;
          request_table.delete(pick);
        end
      end
      OP_REMOVE: begin
        pick = -1;
        foreach (request_table[i]) begin
          if (pick < 0 && request_table[i].tag == req.request_tag) pick = i;
        end
        if (pick >= 0) begin
          request_table.delete(pick);
          res.status = ST_REMOVED;
        end
      end
      default: ;
    endcase
    res.pending_count = PENDING_W'(request_table.size());
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      request_table.delete();
      owed_results.delete();
      head_pos = '0;
      error_count = 0;
      results_owed <= 0;
    end else begin
      // The result side is checked first so that a stray result can never be
      // matched against a request accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected result: status %0d pos %h tag %h count %0d",
                     out_data.status, out_data.chosen_position, out_data.chosen_tag,
                     out_data.pending_count);
          end
        end else begin
          want = owed_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.chosen_position !== want.chosen_position ||
              out_data.chosen_tag !== want.chosen_tag ||
              out_data.pending_count !== want.pending_count) begin
            error_count++;
            if (error_count <= 10) begin
              $display("result mismatch: expected status %0d pos %h tag %h count %0d",
                       want.status, want.chosen_position, want.chosen_tag,
                       want.pending_count);
              $display("                 actual   status %0d pos %h tag %h count %0d",
                       out_data.status, out_data.chosen_position, out_data.chosen_tag,
                       out_data.pending_count);
            end
          end
        end
      end
      if (in_valid && !in_stall) owed_results.push_back(apply_request(in_data));
      results_owed <= owed_results.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the shortest seek request picker with a directed opening and then
// random add, dispatch and remove traffic under several idle and stall mixes,
// including a long receiver hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ssrp_pkg::*;

  localparam int DEPTH        = 32;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 136;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int               error_count;
  int               results_owed;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  bit               hold_req = 1'b0;
  int               quiet_cycles = 0;
  logic [POS_W-1:0] recent_pos = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  shortest_seek_request_picker #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  ssrp_checker #(.DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .error_count (error_count),
    .results_owed(results_owed)
  );

  // Offers one request and returns at the edge where it transfers. Valid is
  // left high so that a following request goes out without a gap.
  task automatic send_request(input op_t op, input logic [POS_W-1:0] pos,
                              input logic [TAG_W-1:0] tag);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, request_position: pos, request_tag: tag};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int add_pct, input int dispatch_pct);
    int               pick;
    op_t              op;
    logic [63:0]      wide;
    logic [POS_W-1:0] pos;
    logic [TAG_W-1:0] tag;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) op = OP_ADD;
    else if (pick < add_pct + dispatch_pct) op = OP_DISPATCH;
    else if (pick < 97) op = OP_REMOVE;
    else op = OP_IGNORE;
    wide = {$urandom, $urandom};
    // Positions mix the full range with clusters, so that equal distances
    // on both sides of the head come up often.
    case ($urandom_range(0, 9))
      0, 1, 2: pos = wide[POS_W-1:0];
      3, 4:    pos = POS_W'($urandom_range(0, 63));
      5: begin
        case ($urandom_range(0, 3))
          0:       pos = '0;
          1:       pos = '1;
          2:       pos = {1'b1, {(POS_W-1){1'b0}}};
          default: pos = {{(POS_W-1){1'b1}}, 1'b0};
        endcase
      end
      default: pos = recent_pos + POS_W'($urandom_range(0, 200)) - POS_W'(100);
    endcase
    // A small tag pool makes removes hit and duplicate tags common.
    if ($urandom_range(0, 3) != 0) tag = TAG_W'($urandom_range(0, 15));
    else tag = TAG_W'($urandom_range(0, 255));
    if (op == OP_ADD) recent_pos = pos;
    send_request(op, pos, tag);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // The receiver stalls at random, or holds off for a long stretch on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_REMOVE, '0, 8'h00);
    send_request(OP_IGNORE, '1, 8'hff);
    send_request(OP_ADD, '1, 8'hff);
    send_request(OP_ADD, '0, 8'h00);
    send_request(OP_ADD, '0, 8'h55);
    send_request(OP_ADD, POS_W'(100), 8'h55);
    // Two entries sit at the head position; the later one must go first.
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_ADD, POS_W'(200), 8'h55);
    send_request(OP_REMOVE, '0, 8'h55);
    send_request(OP_REMOVE, '0, 8'h77);
    send_request(OP_ADD, POS_W'(40), 8'h10);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_ADD, POS_W'(400), 8'h21);
    send_request(OP_DISPATCH, '0, '0);
    // Equal distance above and below the head.
    send_request(OP_ADD, POS_W'(60), 8'h32);
    send_request(OP_ADD, POS_W'(20), 8'h31);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_ADD, '0, 8'haa);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_DISPATCH, '0, '0);
    drain_results();

    // Long receiver hold-off while requests keep coming, then a full drain.
    hold_req = 1'b1;
    repeat (40) send_random(60, 30);
    drain_results();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase / 2)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // Even phases fill the table to full, odd phases empty it again.
      if (phase % 2 == 0) repeat (PHASE_ITEMS) send_random(65, 25);
      else repeat (PHASE_ITEMS) send_random(35, 50);
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (error_count == 0 && results_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
